>>> rtl/core/apfc_pkg.sv
// ----------------------------------------------------------------------------
// apfc_pkg
// shared types and constants of the ambient presence fade controller
// ----------------------------------------------------------------------------
package apfc_pkg;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned LUX_W   = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
   localparam logic [7:0]         MS_MAX     = 8'd255;

   localparam logic [1:0] MODE_AUTO = 2'd0;
   localparam logic [1:0] MODE_ON   = 2'd1;
   localparam logic [1:0] MODE_OFF  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LUX_ON_BELOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LUX_OFF_ABOVE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALARM_ACTIVE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_INTERVAL = 3'd5;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_ON,
      ACT_OFF
   } act_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [LUX_W-1:0]   lux_on_below;
      logic [LUX_W-1:0]   lux_off_above;
      logic [LEVEL_W-1:0] target_level;
      logic               alarm_active;
      logic [7:0]         step_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               lamp;
      logic [7:0]         ms;
   } fade_state_type;

endpackage

>>> rtl/core/ambient_presence_fade_controller_unit.sv
// ----------------------------------------------------------------------------
// ambient_presence_fade_controller_unit
// lamp fade controller driven by 1 ms ticks of light level and presence
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | lux, presence_pin, presence_report
//   rsp     | out       | rsp_valid/rsp_stall | level, lamp_on, lamp_changed
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// one tick per cycle sustained unless rsp stalls; a taken req beat enters the tick register
// the tick register feeds the step logic, which writes state and rsp register
// reset clears state, configuration to defaults and both valid flags
// rsp stall holds a valid rsp register and backs up into req_stall the same cycle
// ----------------------------------------------------------------------------
module ambient_presence_fade_controller_unit
   import apfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [LUX_W-1:0]      req_lux,
   input  logic                  req_presence_pin,
   input  logic                  req_presence_report,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LEVEL_W-1:0]    rsp_level,
   output logic                  rsp_lamp_on,
   output logic                  rsp_lamp_changed,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg;
   logic           alarm_release;
   fade_state_type state_ff;
   fade_state_type state_in;
   fade_state_type nxt;
   logic           changed;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [LUX_W-1:0] in_lux_ff;
   logic             in_present_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic             rsp_lamp_ff;
   logic             rsp_changed_ff;
   logic             advance;
   logic             req_take;

   apfc_csr_regs u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cfg           (cfg),
      .alarm_release (alarm_release)
   );

   apfc_fade_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .lux     (in_lux_ff),
      .present (in_present_ff),
      .nxt     (nxt),
      .changed (changed)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      if (alarm_release) begin
         state_in.level = '0;
      end else if (advance) begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_lux_ff     <= req_lux;
         in_present_ff <= req_presence_pin || req_presence_report;
      end
      if (advance) begin
         rsp_level_ff   <= nxt.level;
         rsp_lamp_ff    <= nxt.lamp;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_lamp_on      = rsp_lamp_ff;
   assign rsp_lamp_changed = rsp_changed_ff;

   // alarm tick drives full brightness
   a_alarm_full: assert property (@(posedge clock) disable iff (reset)
      advance && cfg.alarm_active && !alarm_release |=> state_ff.level == LEVEL_FULL)
      else $error("alarm tick did not reach full brightness");

   // a brightness step restarts the interval count
   a_step_clears_ms: assert property (@(posedge clock) disable iff (reset)
      advance && !cfg.alarm_active && !alarm_release && (nxt.level != state_ff.level)
      |=> state_ff.ms == 8'd0)
      else $error("ramp step without interval restart");

   // reported change matches the lamp state transition
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_changed_ff == (rsp_lamp_ff != $past(state_ff.lamp)))
      else $error("lamp_changed inconsistent with lamp state");

   // a waiting result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !advance)
      else $error("tick retired into a stalled result register");

   // without a queued tick the input side never stalls
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled while tick register empty");

endmodule

>>> rtl/core/apfc_csr_regs.sv
// ----------------------------------------------------------------------------
// apfc_csr_regs
// configuration registers and alarm release detect
// ----------------------------------------------------------------------------
module apfc_csr_regs
   import apfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output logic                  alarm_release
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MODE:          cfg_in.mode             = csr_wdata[1:0];
            REG_LUX_ON_BELOW:  cfg_in.lux_on_below     = csr_wdata[LUX_W-1:0];
            REG_LUX_OFF_ABOVE: cfg_in.lux_off_above    = csr_wdata[LUX_W-1:0];
            REG_TARGET_LEVEL:  cfg_in.target_level     = csr_wdata[LEVEL_W-1:0];
            REG_ALARM_ACTIVE:  cfg_in.alarm_active     = csr_wdata[0];
            REG_STEP_INTERVAL: cfg_in.step_interval_ms = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= MODE_AUTO;
         cfg_ff.lux_on_below     <= 16'd5;
         cfg_ff.lux_off_above    <= 16'd50;
         cfg_ff.target_level     <= 8'd20;
         cfg_ff.alarm_active     <= 1'b0;
         cfg_ff.step_interval_ms <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg           = cfg_ff;
   assign alarm_release = csr_we && (csr_index == REG_ALARM_ACTIVE)
                          && !csr_wdata[0] && cfg_ff.alarm_active;

endmodule

>>> rtl/core/apfc_fade_step.sv
// ----------------------------------------------------------------------------
// apfc_fade_step
// one tick of mode decision and brightness ramp
// ----------------------------------------------------------------------------
module apfc_fade_step
   import apfc_pkg::*;
(
   input  cfg_type          cfg,
   input  fade_state_type   cur,
   input  logic [LUX_W-1:0] lux,
   input  logic             present,
   output fade_state_type   nxt,
   output logic             changed
);

   act_type    act;
   logic [7:0] ms_inc;
   logic       due;

   assign ms_inc = (cur.ms == MS_MAX) ? MS_MAX : cur.ms + 8'd1;
   assign due    = ms_inc > cfg.step_interval_ms;

   always_comb begin
      unique case (cfg.mode)
         MODE_ON:  act = ACT_ON;
         MODE_OFF: act = ACT_OFF;
         default: begin
            if (lux < cfg.lux_on_below) begin
               act = present ? ACT_ON : ACT_OFF;
            end else if (lux > cfg.lux_off_above) begin
               act = ACT_OFF;
            end else begin
               act = ACT_HOLD;
            end
         end
      endcase
   end

   always_comb begin
      nxt       = cur;
      nxt.ms    = ms_inc;
      if (cfg.alarm_active) begin
         nxt.level = LEVEL_FULL;
      end else begin
         unique case (act)
            ACT_ON: begin
               nxt.lamp = 1'b1;
               if ((cur.level != cfg.target_level) && due) begin
                  nxt.level = (cur.level < cfg.target_level) ? cur.level + 8'd1
                                                              : cur.level - 8'd1;
                  nxt.ms    = 8'd0;
               end
            end
            ACT_OFF: begin
               nxt.lamp = 1'b0;
               if ((cur.level != 8'd0) && due) begin
                  nxt.level = cur.level - 8'd1;
                  nxt.ms    = 8'd0;
               end
            end
            default: nxt.lamp = cur.lamp;
         endcase
      end
   end

   assign changed = nxt.lamp != cur.lamp;

endmodule

>>> sim/tb_ambient_presence_fade_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_ambient_presence_fade_controller_unit
// self-checking bench for the ambient presence fade controller
//
// a short directed run walks every mode, the threshold corners, the alarm
// set and clear, a low target and the spare register indexes. Random ticks
// follow in bursts, with the csr settings reshuffled between bursts. Every
// accepted tick goes through a local copy of the fade logic, and each rsp
// beat is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_ambient_presence_fade_controller_unit
   import apfc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_TICKS = 700;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [LUX_W-1:0] lux;
      logic             pin;
      logic             report;
   } tick_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               lamp_on;
      logic               lamp_changed;
   } fade_type;

   typedef enum logic [2:0] {
      LUX_DARK,
      LUX_MID,
      LUX_BRIGHT,
      LUX_EDGE,
      LUX_ANY
   } lux_band_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LUX_W-1:0]      req_lux = '0;
   logic                  req_presence_pin = 1'b0;
   logic                  req_presence_report = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]    rsp_level;
   logic                  rsp_lamp_on;
   logic                  rsp_lamp_changed;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ambient_presence_fade_controller_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_lux             (req_lux),
      .req_presence_pin    (req_presence_pin),
      .req_presence_report (req_presence_report),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level           (rsp_level),
      .rsp_lamp_on         (rsp_lamp_on),
      .rsp_lamp_changed    (rsp_lamp_changed),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and settings
   cfg_type fade_cfg = '{mode: MODE_AUTO, lux_on_below: 16'd5, lux_off_above: 16'd50,
                         target_level: 8'd20, alarm_active: 1'b0, step_interval_ms: 8'd5};
   logic [LEVEL_W-1:0] lamp_level = '0;
   logic               lamp_lit = 1'b0;
   logic [7:0]         ms_count = '0;

   tick_type tick_q[$];
   fade_type pending_fades[$];
   logic  req_took = 1'b0;
   int    send_idle_pct = 32;
   int    stall_pct = 50;
   int    fails = 0;
   int    ticks_seen = 0;
   int    csr_writes = 0;
   int    toggles = 0;
   int    peak_level = 0;
   int    quiet_cycles = 0;

   function automatic fade_type fade_tick(input tick_type t);
      act_type  act;
      logic     was_lit;
      fade_type r;
      was_lit = lamp_lit;
      act = ACT_HOLD;
      if (ms_count != MS_MAX) ms_count = ms_count + 8'd1;
      if (fade_cfg.alarm_active) begin
         lamp_level = LEVEL_FULL;
      end else begin
         case (fade_cfg.mode)
            MODE_ON:  act = ACT_ON;
            MODE_OFF: act = ACT_OFF;
            default: begin
               if (t.lux < fade_cfg.lux_on_below) act = (t.pin | t.report) ? ACT_ON : ACT_OFF;
               else if (t.lux > fade_cfg.lux_off_above) act = ACT_OFF;
            end
         endcase
      end
      if (act == ACT_ON) begin
         lamp_lit = 1'b1;
         if (lamp_level != fade_cfg.target_level && ms_count > fade_cfg.step_interval_ms) begin
            lamp_level = (lamp_level < fade_cfg.target_level) ? lamp_level + 8'd1
                                                              : lamp_level - 8'd1;
            ms_count = '0;
         end
      end else if (act == ACT_OFF) begin
         lamp_lit = 1'b0;
         if (lamp_level != '0 && ms_count > fade_cfg.step_interval_ms) begin
            lamp_level = lamp_level - 8'd1;
            ms_count = '0;
         end
      end
      r.level = lamp_level;
      r.lamp_on = lamp_lit;
      r.lamp_changed = (was_lit != lamp_lit);
      return r;
   endfunction

   function automatic void cfg_apply(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_MODE:          fade_cfg.mode = d[1:0];
         REG_LUX_ON_BELOW:  fade_cfg.lux_on_below = d;
         REG_LUX_OFF_ABOVE: fade_cfg.lux_off_above = d;
         REG_TARGET_LEVEL:  fade_cfg.target_level = d[7:0];
         REG_ALARM_ACTIVE: begin
            if (!d[0] && fade_cfg.alarm_active) lamp_level = '0;
            fade_cfg.alarm_active = d[0];
         end
         REG_STEP_INTERVAL: fade_cfg.step_interval_ms = d[7:0];
         default: ;
      endcase
   endfunction

   function automatic logic [LUX_W-1:0] pick_lux(input lux_band_type b);
      case (b)
         LUX_DARK:
            return (fade_cfg.lux_on_below == '0) ? 16'd0
                   : 16'($urandom_range(32'(fade_cfg.lux_on_below) - 1));
         LUX_BRIGHT:
            return (fade_cfg.lux_off_above == 16'hFFFF) ? 16'hFFFF
                   : 16'($urandom_range(65535, 32'(fade_cfg.lux_off_above) + 1));
         LUX_MID:
            return (fade_cfg.lux_on_below <= fade_cfg.lux_off_above)
                   ? 16'($urandom_range(fade_cfg.lux_off_above, fade_cfg.lux_on_below))
                   : 16'($urandom);
         LUX_EDGE: begin
            case ($urandom_range(5))
               0: return 16'd0;
               1: return 16'hFFFF;
               2: return fade_cfg.lux_on_below;
               3: return fade_cfg.lux_on_below - 16'd1;
               4: return fade_cfg.lux_off_above;
               default: return fade_cfg.lux_off_above + 16'd1;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // driver: one tick beat per handshake, payload held while stalled
   always @(negedge clock) begin : drive_ticks
      tick_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = tick_q.pop_front();
            req_valid <= 1'b1;
            req_lux <= nxt.lux;
            req_presence_pin <= nxt.pin;
            req_presence_report <= nxt.report;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: predict on req beats, check on rsp beats
   always @(posedge clock) begin : watch_beats
      tick_type seen;
      fade_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.lux = req_lux;
            seen.pin = req_presence_pin;
            seen.report = req_presence_report;
            want = fade_tick(seen);
            pending_fades.push_back(want);
            ticks_seen++;
            if (want.lamp_changed) toggles++;
            if (int'(want.level) > peak_level) peak_level = int'(want.level);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_fades.size() == 0) begin
               $error("rsp beat with no pending tick");
               fails++;
            end else begin
               want = pending_fades.pop_front();
               if (rsp_level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, rsp_level);
                  fails++;
               end
               if (rsp_lamp_on !== want.lamp_on) begin
                  $error("lamp_on: expected %0d, got %0d", want.lamp_on, rsp_lamp_on);
                  fails++;
               end
               if (rsp_lamp_changed !== want.lamp_changed) begin
                  $error("lamp_changed: expected %0d, got %0d",
                         want.lamp_changed, rsp_lamp_changed);
                  fails++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no beat moved for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_tick(input logic [LUX_W-1:0] lux, input logic pin, input logic report);
      tick_type t;
      t.lux = lux;
      t.pin = pin;
      t.report = report;
      tick_q.push_back(t);
   endtask

   task automatic drain_fades();
      while (tick_q.size() != 0 || req_valid || pending_fades.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_apply(idx, d);
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic shuffle_cfg();
      int r;
      r = $urandom_range(9);
      if ($urandom_range(99) < 60)
         csr_write(REG_MODE, {14'($urandom), (r < 5) ? MODE_AUTO : (r < 7) ? MODE_ON :
                                             (r < 9) ? MODE_OFF : MODE_SPARE});
      if ($urandom_range(99) < 50)
         csr_write(REG_LUX_ON_BELOW, ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(2000)));
      if ($urandom_range(99) < 50)
         csr_write(REG_LUX_OFF_ABOVE, ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                                              : 16'($urandom_range(3000, 1)));
      if ($urandom_range(99) < 50) begin
         r = $urandom_range(7);
         csr_write(REG_TARGET_LEVEL, {8'($urandom), (r == 0) ? 8'($urandom_range(4)) :
                                      (r == 1) ? LEVEL_FULL : 8'($urandom_range(255, 5))});
      end
      if ($urandom_range(99) < 50) begin
         r = $urandom_range(19);
         csr_write(REG_STEP_INTERVAL, {8'($urandom), (r == 0) ? 8'd254 :
                                       (r < 3) ? 8'($urandom_range(254, 4)) :
                                       8'($urandom_range(3))});
      end
      if (fade_cfg.alarm_active ? ($urandom_range(99) < 70) : ($urandom_range(99) < 8))
         csr_write(REG_ALARM_ACTIVE, {15'($urandom), !fade_cfg.alarm_active});
      else if ($urandom_range(99) < 5)
         csr_write(REG_ALARM_ACTIVE, {15'($urandom), fade_cfg.alarm_active});
   endtask

   initial begin : run_ticks
      lux_band_type band;
      logic         pin;
      logic         report;
      int           left;
      int           burst;
      band = LUX_DARK;
      pin = 1'b1;
      report = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // power-up settings, auto mode
      queue_tick(16'd0, 1'b1, 1'b0);
      queue_tick(16'd0, 1'b0, 1'b1);
      queue_tick(16'd0, 1'b0, 1'b0);
      queue_tick(16'd4, 1'b1, 1'b1);
      queue_tick(16'hFFFF, 1'b1, 1'b1);
      queue_tick(16'd30, 1'b1, 1'b1);
      drain_fades();
      // forced on toward a target below the nominal floor
      csr_write(REG_STEP_INTERVAL, 16'd0);
      csr_write(REG_TARGET_LEVEL, 16'd3);
      csr_write(REG_MODE, {14'd0, MODE_ON});
      repeat (4) queue_tick(16'd100, 1'b0, 1'b0);
      drain_fades();
      csr_write(REG_TARGET_LEVEL, 16'd0);
      queue_tick(16'd100, 1'b0, 1'b0);
      drain_fades();
      csr_write(REG_MODE, {14'd0, MODE_OFF});
      repeat (2) queue_tick(16'hFFFF, 1'b1, 1'b1);
      drain_fades();
      // spare mode code with crossed thresholds
      csr_write(REG_MODE, {14'h3FFF, MODE_SPARE});
      csr_write(REG_LUX_ON_BELOW, 16'hFFFF);
      csr_write(REG_LUX_OFF_ABOVE, 16'd1);
      queue_tick(16'hFFFE, 1'b1, 1'b0);
      queue_tick(16'hFFFE, 1'b0, 1'b0);
      queue_tick(16'hFFFF, 1'b1, 1'b1);
      drain_fades();
      // thresholds at their extremes so every lux holds
      csr_write(REG_MODE, {14'd0, MODE_AUTO});
      csr_write(REG_LUX_ON_BELOW, 16'd0);
      csr_write(REG_LUX_OFF_ABOVE, 16'hFFFF);
      queue_tick(16'd0, 1'b1, 1'b1);
      queue_tick(16'hFFFF, 1'b1, 1'b1);
      drain_fades();
      // alarm set, then cleared
      csr_write(REG_ALARM_ACTIVE, 16'd1);
      repeat (2) queue_tick(16'd0, 1'b0, 1'b0);
      drain_fades();
      csr_write(REG_ALARM_ACTIVE, 16'hFFFE);
      queue_tick(16'd0, 1'b0, 1'b0);
      drain_fades();
      // slowest step interval, full target
      csr_write(REG_STEP_INTERVAL, 16'hFF00 | 16'd254);
      csr_write(REG_TARGET_LEVEL, 16'h00FF);
      csr_write(REG_MODE, {14'd0, MODE_ON});
      repeat (2) queue_tick(16'd0, 1'b1, 1'b0);
      drain_fades();
      // writes to unused indexes change nothing
      csr_write(REG_SPARE_LO, 16'hFFFF);
      csr_write(REG_SPARE_HI, 16'hFFFF);
      queue_tick(16'd0, 1'b1, 1'b0);
      drain_fades();

      // random bursts, settings reshuffled while the block is drained
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 50 : 0;
         stall_pct = (phase == 0) ? 50 : (phase == 1) ? 32 : 0;
         left = (phase == 2) ? RANDOM_TICKS - 2 * (RANDOM_TICKS / 3) : RANDOM_TICKS / 3;
         while (left > 0) begin
            shuffle_cfg();
            burst = $urandom_range(60, 20);
            if (burst > left) burst = left;
            left -= burst;
            repeat (burst) begin
               if ($urandom_range(99) < 15) band = lux_band_type'($urandom_range(4));
               if ($urandom_range(99) < 15) begin
                  pin = $urandom_range(1);
                  report = $urandom_range(1);
               end
               queue_tick(pick_lux(band), pin, report);
            end
            drain_fades();
         end
      end

      repeat (8) @(negedge clock);
      if (pending_fades.size() != 0) begin
         $error("%0d predicted results never arrived", pending_fades.size());
         fails++;
      end
      $display("%0d ticks checked across %0d csr writes, %0d lamp toggles, peak level %0d",
               ticks_seen, csr_writes, toggles, peak_level);
      $display("auto, forced on/off, spare mode, alarm and threshold corners exercised");
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/apfc_pkg.sv
rtl/core/apfc_csr_regs.sv
rtl/core/apfc_fade_step.sv
rtl/core/ambient_presence_fade_controller_unit.sv
sim/tb_ambient_presence_fade_controller_unit.sv
